FILE: rtl/rep_pkg.sv
// Shared types, constants and register codes for the ranged pattern search block.
`timescale 1ns / 1ps

package rep_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  // The pattern registers always hold sixteen bytes, whatever the window depth.
  localparam int PAT_BYTES   = 16;
  localparam int LEN_W       = 5;
  localparam int POS_OUT_W   = 32;
  localparam int RANGE_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  typedef logic [7:0] byte_t;
  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAT_LOW   = 3'd0,
    CFG_PAT_HIGH  = 3'd1,
    CFG_PAT_LEN   = 3'd2,
    CFG_RNG_START = 3'd3,
    CFG_RNG_END   = 3'd4
  } cfg_index_e;

  typedef struct packed {
    pattern_t             pattern;
    logic [LEN_W-1:0]     pat_len;
    logic [RANGE_W-1:0]   range_start;
    logic [RANGE_W-1:0]   range_end;
  } rep_cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: rtl/rep_if.sv
// Valid/ready channel interfaces for the text input and the match output.
`timescale 1ns / 1ps

interface rep_in_if
  import rep_pkg::*;
  ;
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface rep_out_if
  import rep_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] match_position;
  logic                 at_text_end;

  modport source (output valid, output match_position, output at_text_end, input ready);
  modport sink   (input valid, input match_position, input at_text_end, output ready);
endinterface

FILE: rtl/rep_cfg.sv
// Configuration register file for the pattern, its length and the position range.
`timescale 1ns / 1ps

module rep_cfg
  import rep_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output rep_cfg_t               cfg
);

  rep_cfg_t cfg_r;
  rep_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index_e'(cfg_index))
        CFG_PAT_LOW:   cfg_nxt.pattern[7:0]  = cfg_wdata;
        CFG_PAT_HIGH:  cfg_nxt.pattern[15:8] = cfg_wdata;
        CFG_PAT_LEN:   cfg_nxt.pat_len       = cfg_wdata[LEN_W-1:0];
        CFG_RNG_START: cfg_nxt.range_start   = cfg_wdata[RANGE_W-1:0];
        CFG_RNG_END:   cfg_nxt.range_end     = cfg_wdata[RANGE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern     <= '0;
      cfg_r.pat_len     <= '0;
      cfg_r.range_start <= '0;
      cfg_r.range_end   <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/rep_cell.sv
// One window cell: holds a text byte, passes it on, and compares it to its pattern byte.
`timescale 1ns / 1ps

module rep_cell
  import rep_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  byte_t            byte_in,
  input  pattern_t         pattern,
  input  logic [LEN_W-1:0] pat_len,
  output byte_t            byte_out,
  output logic             eq_out
);

  localparam int PAT_IDX_W = $clog2(PAT_BYTES);

  byte_t                  byte_r;
  byte_t                  byte_nxt;
  logic                   eq_r;
  logic                   eq_nxt;
  logic                   in_use;
  logic [PAT_IDX_W-1:0]   pat_idx;

  // Cell IDX holds the byte IDX places behind the newest one, which lines up
  // with pattern byte len-1-IDX for the current pattern length.
  assign in_use  = LEN_W'(IDX) < pat_len;
  assign pat_idx = PAT_IDX_W'(pat_len - LEN_W'(IDX) - LEN_W'(1));

  always_comb begin
    byte_nxt = byte_r;
    eq_nxt   = eq_r;
    if (ctl.shift) begin
      eq_nxt   = !in_use || (byte_in == pattern[pat_idx]);
      byte_nxt = ctl.clear ? '0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    eq_r   <= eq_nxt;
  end

  assign byte_out = byte_r;
  assign eq_out   = eq_r;

endmodule

FILE: rtl/ranged_exact_pattern_search_top.sv
// Top level of the ranged exact pattern search: cell chain, match stage and output register.
// A match passes through the match stage and then the output register before it is shown on the output.
// Throughput: one text byte per cycle, unless a match in the match stage waits on a stalled output.
// A stalled output holds one result while bytes are still taken; a match in the match stage then blocks the input.
// Reset (synchronous, rst_n low) clears position, fill count, pipeline valids and configuration registers;
// range_end resets to all ones, the other registers to zero.
`timescale 1ns / 1ps

module ranged_exact_pattern_search_top
  import rep_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rep_in_if.sink                 in_chan,
  rep_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  // Configuration registers.
  rep_cfg_t cfg;

  rep_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake and control. A beat is taken whenever the match stage is empty
  // or is about to hand its content on (or drop it when it is no match).
  logic acc;
  logic in_ready;
  logic last_beat;
  cell_ctl_t ctl;

  assign last_beat = in_chan.last_byte;
  assign acc       = in_chan.valid && in_ready;
  assign ctl.shift = acc;
  assign ctl.clear = last_beat;

  // Chain of cells. Cell 0 takes the incoming byte; each later cell takes its
  // neighbor's byte, so cell k holds the byte k places behind the newest one.
  // Each cell registers whether its new byte equals the pattern byte that
  // lines up with it, or that it lies beyond the pattern length.
  byte_t                  win   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    byte_t prev_byte;
    if (k == 0) begin : g_head
      assign prev_byte = in_chan.text_byte;
    end else begin : g_body
      assign prev_byte = win[k-1];
    end

    rep_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .byte_in  (prev_byte),
      .pattern  (cfg.pattern),
      .pat_len  (cfg.pat_len),
      .byte_out (win[k]),
      .eq_out   (eq_vec[k])
    );
  end

  // Position of the incoming byte and count of the current text's bytes held
  // in the chain, saturating at the chain depth.
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic [FILL_W-1:0]        fill_inc;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     len_ok;
  logic                     range_ok;

  assign fill_inc  = (fill_r < FILL_W'(MAX_PATTERN)) ? fill_r + FILL_W'(1) : fill_r;
  assign start_pos = pos_r - POSITION_BITS'(cfg.pat_len - LEN_W'(1));

  // The pattern must be non-empty, fit the chain and be covered by bytes of
  // the current text; the occurrence must start and end inside the range.
  assign len_ok   = (cfg.pat_len != '0) && (cfg.pat_len <= LEN_W'(MAX_PATTERN)) &&
                    (LEN_W'(fill_inc) >= cfg.pat_len);
  assign range_ok = (RANGE_W'(start_pos) >= cfg.range_start) &&
                    (RANGE_W'(pos_r) <= cfg.range_end);

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (acc) begin
      pos_nxt  = last_beat ? '0 : pos_r + POSITION_BITS'(1);
      fill_nxt = last_beat ? '0 : fill_inc;
    end
  end

  // Match stage: holds the length and range verdict, the last-byte flag and the start position
  // of the beat whose comparisons sit in the cells.
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_ok_r, s1_ok_nxt;
  logic                     s1_last_r, s1_last_nxt;
  logic [POSITION_BITS-1:0] s1_start_r, s1_start_nxt;
  logic                     s1_hit;
  logic                     s1_drain;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [POS_OUT_W-1:0]     out_pos_r, out_pos_nxt;
  logic                     out_end_r, out_end_nxt;
  logic                     out_free;

  assign s1_hit   = s1_valid_r && s1_ok_r && (&eq_vec);
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_drain = s1_valid_r && (!s1_hit || out_free);
  assign in_ready = !s1_valid_r || s1_drain;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ok_nxt    = s1_ok_r;
    s1_last_nxt  = s1_last_r;
    s1_start_nxt = s1_start_r;
    if (s1_drain) begin
      s1_valid_nxt = 1'b0;
    end
    if (acc) begin
      s1_valid_nxt = 1'b1;
      s1_ok_nxt    = len_ok && range_ok;
      s1_last_nxt  = last_beat;
      s1_start_nxt = start_pos;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_end_nxt   = out_end_r;
    if (out_free) begin
      out_valid_nxt = s1_hit;
      if (s1_hit) begin
        out_pos_nxt = POS_OUT_W'(s1_start_r);
        out_end_nxt = s1_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r    <= s1_ok_nxt;
    s1_last_r  <= s1_last_nxt;
    s1_start_r <= s1_start_nxt;
    out_pos_r  <= out_pos_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.match_position = out_pos_r;
  assign out_chan.at_text_end    = out_end_r;

  // A pending match facing a stalled output must block the input.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_hit && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while a match could not move on");

  // The fill count never passes the chain depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_PATTERN))
    else $error("window fill count out of range");

  // A text's last byte restarts position and fill.
  a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_beat) |=> (pos_r == '0 && fill_r == '0))
    else $error("position or fill not cleared after the last byte");

endmodule
